>>> hw/rtl/spg_pkg.sv
// Shared types and constants for the stepper step/direction pulse generator.
// Depends on nothing; imported by stepper_position_pulse_generator_unit.
`default_nettype none

package spg_pkg;

  // steps in one revolution and derived constants
  localparam int StepsPerRev = 200;
  localparam int HalfRev     = StepsPerRev / 2;
  // tenths of a degree per step (revolution is 3600 tenths)
  localparam int AngleScale  = 3600 / StepsPerRev;

  // reciprocal for magnitude / AngleScale, exact for 16-bit magnitudes
  localparam int DegShift = 20;
  localparam int DegMul   = ((1 << DegShift) + AngleScale - 1) / AngleScale;
  localparam int QDegW    = $clog2((1 << 15) / AngleScale + 1);

  // reciprocal for magnitude / StepsPerRev, exact for 16-bit magnitudes
  localparam int RevShift = 24;
  localparam int RevMul   = ((1 << RevShift) + StepsPerRev - 1) / StepsPerRev;
  localparam int QRevW    = $clog2((1 << 15) / StepsPerRev + 1);
  localparam int RemW     = $clog2(StepsPerRev);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // signed intermediate wide enough for position sums and differences
  typedef logic signed [9:0] pos_t;

  typedef enum logic [2:0] {
    OpTick      = 3'd0,
    OpMoveRel   = 3'd1,
    OpMoveStep  = 3'd2,
    OpMoveAngle = 3'd3,
    OpZero      = 3'd4,
    OpRelease   = 3'd5
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReverse    = 2'd0,
    CfgActiveLow  = 2'd1,
    CfgHalfPeriod = 2'd2
  } cfg_idx_e;

  localparam logic [CfgDataW-1:0] HalfPeriodReset = 24'd1000;

  // operand capture stage
  typedef struct packed {
    op_e              op;
    logic [15:0]      mag;
    logic             neg;
    logic             pos;
    logic [QDegW-1:0] q_deg;
  } s1_t;

  // modulo quotient stage
  typedef struct packed {
    op_e              op;
    logic [15:0]      mag;
    logic             neg;
    logic [QRevW-1:0] q_rev;
    logic [15:0]      rel_abs;
    logic             rel_dir;
  } s2_t;

  // reduced operand stage
  typedef struct packed {
    op_e         op;
    pos_t        wrapped;
    logic [15:0] rel_abs;
    logic        rel_dir;
  } s3_t;

  // fold a value within one revolution of the range into (-N/2, N/2]
  function automatic pos_t wrap_pos(pos_t x);
    pos_t r;
    r = x;
    if (x > pos_t'(HalfRev)) begin
      r = x - pos_t'(StepsPerRev);
    end else if (x <= -pos_t'(HalfRev)) begin
      r = x + pos_t'(StepsPerRev);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stepper_position_pulse_generator_unit.sv
// Stepper motor step/direction pulse generator, top level.
// Depends on spg_pkg for op codes, register indexes, stage types and constants.
`default_nettype none

// Takes one request per clock while the output does not stall (tick, relative
// move, move to step, move to angle, zero position, release) and returns one
// result per request. Three stages reduce the request operand without looking
// at the motor state: a reciprocal multiply for the angle-to-step conversion, a
// reciprocal multiply for the quotient by steps per revolution, then the
// remainder folded into (-N/2, N/2]. The last stage updates position, pulse
// count and tick counter and loads the result register, so back-to-back
// requests that depend on each other's state still run at one per clock while
// the output does not stall. A move, zero or release while pulses are pending
// is rejected. Configuration writes are expected only while the pipe is empty.
module stepper_position_pulse_generator_unit
  import spg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          operation_i,
  input  wire logic signed [15:0]  value_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     step_level_o,
  output logic                     dir_level_o,
  output logic                     enable_level_o,
  output logic signed [7:0]        position_o,
  output logic signed [11:0]       angle_o,
  output logic                     busy_res_o,
  output logic                     rejected_o
);

  // configuration
  logic                rev_q;
  logic                active_low_q;
  logic [CfgDataW-1:0] half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q        <= 1'b0;
      active_low_q <= 1'b0;
      half_q       <= HalfPeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgReverse:    rev_q        <= cfg_data_i[0];
        CfgActiveLow:  active_low_q <= cfg_data_i[0];
        CfgHalfPeriod: half_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_q, v2_q, v3_q, out_v_q;
  logic rdy1, rdy2, rdy3, out_free, go_out;

  assign out_free   = !out_v_q || !out_stall_i;
  assign go_out     = v3_q && out_free;
  assign rdy3       = !v3_q || go_out;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (out_free) begin
        out_v_q <= v3_q;
      end
    end
  end

  // stage 1: magnitude, sign and angle-to-step quotient
  s1_t         s1_d, s1_q;
  logic [15:0] abs_v;
  logic [31:0] deg_prod;

  always_comb begin
    abs_v       = value_i[15] ? 16'(-value_i) : 16'(value_i);
    deg_prod    = 32'(abs_v) * 32'(DegMul);
    s1_d.op     = op_e'(operation_i);
    s1_d.mag    = abs_v;
    s1_d.neg    = value_i[15];
    s1_d.pos    = !value_i[15] && (value_i != 16'sd0);
    s1_d.q_deg  = QDegW'(deg_prod >> DegShift);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: pick the operand to fold and take its quotient by the revolution
  s2_t         s2_d, s2_q;
  logic [15:0] fold_mag;
  logic        fold_neg;
  logic [32:0] rev_prod;

  always_comb begin
    fold_mag = s1_q.mag;
    fold_neg = s1_q.neg;
    case (s1_q.op)
      // relative move folds the count after polarity
      OpMoveRel: fold_neg = rev_q ? s1_q.pos : s1_q.neg;
      OpMoveAngle: fold_mag = 16'(s1_q.q_deg);
      default: ;
    endcase
    rev_prod     = 33'(fold_mag) * 33'(RevMul);
    s2_d.op      = s1_q.op;
    s2_d.mag     = fold_mag;
    s2_d.neg     = fold_neg;
    s2_d.q_rev   = QRevW'(rev_prod >> RevShift);
    s2_d.rel_abs = s1_q.mag;
    s2_d.rel_dir = rev_q ? s1_q.neg : s1_q.pos;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: remainder, then signed fold into (-N/2, N/2]
  s3_t             s3_d, s3_q;
  logic [15:0]     q_times_n;
  logic [RemW-1:0] rem;
  logic [RemW-1:0] rem_pos;

  always_comb begin
    q_times_n = 16'(16'(s2_q.q_rev) * 16'(StepsPerRev));
    rem       = RemW'(s2_q.mag - q_times_n);
    rem_pos   = (s2_q.neg && (rem != '0)) ? RemW'(RemW'(StepsPerRev) - rem) : rem;
    s3_d.op      = s2_q.op;
    s3_d.wrapped = (pos_t'(rem_pos) > pos_t'(HalfRev))
                   ? pos_t'(rem_pos) - pos_t'(StepsPerRev) : pos_t'(rem_pos);
    s3_d.rel_abs = s2_q.rel_abs;
    s3_d.rel_dir = s2_q.rel_dir;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_q <= s3_d;
    end
  end

  // stage 4: motor state update
  logic signed [7:0]   pos_q, pos_d;
  logic [15:0]         pulses_q, pulses_d;
  logic                phase_q, phase_d;
  logic [CfgDataW-1:0] tick_q, tick_d;
  logic                dir_q, dir_d;
  logic                en_q, en_d;
  logic                rej_d;

  logic                busy;
  pos_t                p_cur, d_step, sd, mv_off, mv_pos;
  logic                mv_dir;
  logic [15:0]         mv_abs;
  logic [CfgDataW-1:0] tick_inc;
  logic [15:0]         pulses_dec;

  always_comb begin
    busy   = pulses_q != '0;
    p_cur  = pos_t'(pos_q);
    d_step = wrap_pos(s3_q.wrapped - p_cur);
    sd     = rev_q ? -d_step : d_step;
    if (s3_q.op == OpMoveRel) begin
      mv_off = s3_q.wrapped;
      mv_dir = s3_q.rel_dir;
      mv_abs = s3_q.rel_abs;
    end else begin
      mv_off = sd;
      mv_dir = sd > pos_t'(0);
      mv_abs = 16'((sd < pos_t'(0)) ? -sd : sd);
    end
    mv_pos     = wrap_pos(p_cur + mv_off);
    tick_inc   = tick_q + CfgDataW'(1);
    pulses_dec = pulses_q - 16'd1;

    pos_d    = pos_q;
    pulses_d = pulses_q;
    phase_d  = phase_q;
    tick_d   = tick_q;
    dir_d    = dir_q;
    en_d     = en_q;
    rej_d    = 1'b0;

    case (s3_q.op)
      OpTick: begin
        if (busy) begin
          if (tick_inc >= half_q) begin
            tick_d = '0;
            if (phase_q) begin
              phase_d = 1'b0;
            end else begin
              pulses_d = pulses_dec;
              phase_d  = pulses_dec != '0;
            end
          end else begin
            tick_d = tick_inc;
          end
        end
      end
      OpMoveRel, OpMoveStep, OpMoveAngle: begin
        if (busy) begin
          rej_d = 1'b1;
        end else begin
          pos_d    = 8'(mv_pos);
          dir_d    = mv_dir;
          en_d     = 1'b1;
          pulses_d = mv_abs;
          tick_d   = '0;
          phase_d  = mv_abs != '0;
        end
      end
      OpZero: begin
        if (busy) begin
          rej_d = 1'b1;
        end else begin
          pos_d = '0;
        end
      end
      OpRelease: begin
        if (busy) begin
          rej_d = 1'b1;
        end else begin
          en_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pulses_q <= '0;
      phase_q  <= 1'b0;
      tick_q   <= '0;
      dir_q    <= 1'b0;
      en_q     <= 1'b0;
    end else if (go_out) begin
      pos_q    <= pos_d;
      pulses_q <= pulses_d;
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      dir_q    <= dir_d;
      en_q     <= en_d;
    end
  end

  // result register
  logic               step_q, dir_out_q, en_out_q, busy_out_q, rej_q;
  logic signed [7:0]  pos_out_q;
  logic signed [11:0] angle_q, angle_d;

  // angle is exact because the revolution divides 3600
  assign angle_d = 12'(pos_d) * 12'(AngleScale);

  always_ff @(posedge clk_i) begin
    if (go_out) begin
      step_q     <= phase_d;
      dir_out_q  <= dir_d;
      en_out_q   <= en_d ^ active_low_q;
      pos_out_q  <= pos_d;
      angle_q    <= angle_d;
      busy_out_q <= pulses_d != '0;
      rej_q      <= rej_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign step_level_o   = step_q;
  assign dir_level_o    = dir_out_q;
  assign enable_level_o = en_out_q;
  assign position_o     = pos_out_q;
  assign angle_o        = angle_q;
  assign busy_res_o     = busy_out_q;
  assign rejected_o     = rej_q;

`ifndef SYNTHESIS
  // a rejected request leaves pulses pending
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o)
    else $error("rejected result without pending pulses");

  // step pin only high while pulses remain
  a_phase_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (pulses_q != '0))
    else $error("step phase high with no pulses left");

  // tick counter is parked at zero when idle
  a_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pulses_q == '0) |-> (tick_q == '0))
    else $error("tick counter nonzero while idle");

  // tracked position stays in (-N/2, N/2]
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_t'(pos_q) <= pos_t'(HalfRev)) && (pos_t'(pos_q) > -pos_t'(HalfRev)))
    else $error("position out of half revolution range");
`endif

endmodule

`default_nettype wire
